@@ rtl/core/fmab_pkg.sv @@
// ----------------------------------------------------------------------------
// fmab_pkg
// Types and constants shared by the broadcast delivery engine.
// ----------------------------------------------------------------------------
package fmab_pkg;

  localparam int unsigned MaxProc = 16;
  localparam int unsigned Window  = 32;
  localparam int unsigned PidW    = $clog2(MaxProc);
  localparam int unsigned WinW    = $clog2(Window);
  localparam int unsigned SlotW   = PidW + WinW;
  localparam int unsigned Depth   = MaxProc * Window;

  localparam logic [1:0] ReqBcast = 2'd0;
  localparam logic [1:0] ReqCopy  = 2'd1;
  localparam logic [1:0] ReqAck   = 2'd2;
  localparam logic [1:0] ReqRsvd  = 2'd3;

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActDeliver = 2'd1;
  localparam logic [1:0] ActDrop = 2'd2;

  localparam logic CfgNumProc = 1'b0;
  localparam logic CfgMyId    = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  origin_id;
    logic [31:0] seq_num;
    logic [3:0]  from_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  out_origin;
    logic [31:0] out_seq;
    logic        last;
  } out_t;

  // slot entry: pending bit and holder bitmap
  typedef struct packed {
    logic               pend;
    logic [MaxProc-1:0] acks;
  } slot_t;

endpackage

@@ rtl/core/fmab_slot_ram.sv @@
// ----------------------------------------------------------------------------
// fmab_slot_ram
// Slot store with a registered read port and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module fmab_slot_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       busy_o,
  input  logic [fmab_pkg::SlotW-1:0] raddr_i,
  output fmab_pkg::slot_t            rdata_o,
  input  logic                       we_i,
  input  logic [fmab_pkg::SlotW-1:0] waddr_i,
  input  fmab_pkg::slot_t            wdata_i
);
  fmab_pkg::slot_t mem_q [fmab_pkg::Depth];
  fmab_pkg::slot_t rd_q;
  logic [fmab_pkg::SlotW-1:0] clr_q;
  logic clr_busy_q;
  logic wen;
  logic [fmab_pkg::SlotW-1:0] wa;
  fmab_pkg::slot_t wd;

  assign wen = clr_busy_q | we_i;
  assign wa  = clr_busy_q ? clr_q : waddr_i;
  assign wd  = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wen) mem_q[wa] <= wd;
    rd_q <= mem_q[raddr_i];
  end

  // sweep every entry once after reset, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == '1) clr_busy_q <= 1'b0;
    end
  end

  assign busy_o  = clr_busy_q;
  assign rdata_o = rd_q;
endmodule

@@ rtl/core/fifo_majority_ack_broadcast_delivery_top.sv @@
// ----------------------------------------------------------------------------
// fifo_majority_ack_broadcast_delivery_top
// Uniform reliable broadcast engine with in-order majority-ack delivery.
// ----------------------------------------------------------------------------
// Order of states: an accepted item goes Idle, Read, Mod; a send beat is emitted
// from Emit, each delivered message passes CRd, CChk and Emit (the next slot is
// read ahead to set last), and a drop goes from Idle straight to Emit.
// Items run one at a time; a stall on the result port holds the engine in Emit.
// Reset: next expected 1, counter 0; a sweep clears every slot while the input
// stalls.
module fifo_majority_ack_broadcast_delivery_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fmab_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fmab_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [4:0]      cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMod  = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;
  localparam logic [2:0] StCRd  = 3'd4;
  localparam logic [2:0] StCChk = 3'd5;

  logic [2:0] st_q;
  logic [4:0] np_q;
  logic [3:0] me_q;
  logic [31:0] ne_q [fmab_pkg::MaxProc];
  logic [31:0] own_q;
  fmab_pkg::in_t it_q;
  logic [3:0] org_q;
  logic [31:0] seq_q;
  logic chain_q; // another delivery beat follows the current one
  logic out_valid_q;
  fmab_pkg::out_t out_data_q;

  logic [fmab_pkg::SlotW-1:0] raddr, waddr;
  fmab_pkg::slot_t rdata, wdata;
  logic we;
  logic ram_busy;
  logic [31:0] chk_seq;

  fmab_slot_ram u_ram (
    .clk_i, .rst_ni, .busy_o(ram_busy), .raddr_i(raddr), .rdata_o(rdata),
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata)
  );

  logic [31:0] ne_sel;
  assign ne_sel = ne_q[org_q];
  // chain states look one slot ahead of the beat being delivered
  assign chk_seq = (st_q == StCRd || st_q == StCChk) ? seq_q + 32'd1 : seq_q;
  assign raddr = {org_q, chk_seq[fmab_pkg::WinW-1:0]};
  assign waddr = raddr;

  function automatic logic [fmab_pkg::MaxProc-1:0] bitof(input logic [3:0] p);
    bitof = '0;
    bitof[p] = 1'b1;
  endfunction

  logic [4:0] cnt;
  fmab_pkg::slot_t mod;
  logic rdy, newsend, del;
  always_comb begin
    mod = rdata;
    newsend = 1'b0;
    if (it_q.req_type == fmab_pkg::ReqBcast) begin
      mod.pend = 1'b1;
      mod.acks = mod.acks | bitof(me_q);
    end else begin
      mod.acks = mod.acks | bitof(it_q.from_id);
      if (it_q.req_type == fmab_pkg::ReqCopy && !rdata.pend) begin
        newsend = 1'b1;
        mod.pend = 1'b1;
        mod.acks = mod.acks | bitof(me_q);
      end
    end
    if (st_q == StCChk) mod = rdata;
    cnt = '0;
    for (int i = 0; i < fmab_pkg::MaxProc; i++) cnt = cnt + 5'(mod.acks[i]);
    rdy = mod.pend && (chk_seq == ne_sel) && (chk_seq != '1) && (cnt > (np_q >> 1));
    // a broadcast never delivers by itself
    del = rdy && (st_q == StCChk || it_q.req_type != fmab_pkg::ReqBcast);
  end

  always_comb begin
    we = (st_q == StMod) || (st_q == StCChk && del);
    wdata = del ? '0 : mod;
  end

  logic inwin;
  logic [32:0] diff;
  always_comb begin
    diff = {1'b0, in_data_i.seq_num} - {1'b0, ne_q[in_data_i.origin_id]};
    inwin = (in_data_i.seq_num != '1) && (diff < 33'(fmab_pkg::Window));
  end
  logic [32:0] bdiff;
  logic [31:0] bseq;
  assign bseq = own_q + 32'd1;
  assign bdiff = {1'b0, bseq} - {1'b0, ne_q[me_q]};

  assign in_stall_o  = (st_q != StIdle) || ram_busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      np_q <= 5'd2;
      me_q <= '0;
      own_q <= '0;
      it_q <= '0;
      org_q <= '0;
      seq_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
      chain_q <= 1'b0;
      for (int i = 0; i < fmab_pkg::MaxProc; i++) ne_q[i] <= 32'd1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fmab_pkg::CfgNumProc) np_q <= cfg_data_i;
        else me_q <= cfg_data_i[3:0];
      end
      unique case (st_q)
        StIdle: begin
          if (in_valid_i && !ram_busy) begin
            it_q <= in_data_i;
            chain_q <= 1'b0;
            if (in_data_i.req_type == fmab_pkg::ReqBcast) begin
              org_q <= me_q;
              seq_q <= bseq;
              if (own_q != '1) begin
                if (bseq != '1 && bdiff < 33'(fmab_pkg::Window)) begin
                  own_q <= bseq;
                  st_q <= StRead;
                end else begin
                  out_data_q <= '{fmab_pkg::ActDrop, me_q, bseq, 1'b1};
                  out_valid_q <= 1'b1;
                  st_q <= StEmit;
                end
              end
            end else if ((in_data_i.req_type == fmab_pkg::ReqCopy ||
                          in_data_i.req_type == fmab_pkg::ReqAck) &&
                         in_data_i.seq_num >= ne_q[in_data_i.origin_id]) begin
              org_q <= in_data_i.origin_id;
              seq_q <= in_data_i.seq_num;
              if (inwin) st_q <= StRead;
              else begin
                out_data_q <= '{fmab_pkg::ActDrop, in_data_i.origin_id,
                                in_data_i.seq_num, 1'b1};
                out_valid_q <= 1'b1;
                st_q <= StEmit;
              end
            end
          end
        end
        StRead: st_q <= StMod;
        StMod: begin
          chain_q <= del;
          if (del) ne_q[org_q] <= seq_q + 32'd1;
          if (it_q.req_type == fmab_pkg::ReqBcast || newsend) begin
            // the deliver beat, if any, follows the send beat
            out_data_q <= '{fmab_pkg::ActSend, org_q, seq_q, !del};
            out_valid_q <= 1'b1;
            st_q <= StEmit;
          end else if (del) st_q <= StCRd;
          else st_q <= StIdle;
        end
        StEmit: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            st_q <= chain_q ? StCRd : StIdle;
          end
        end
        StCRd: st_q <= StCChk;
        StCChk: begin
          // deliver seq_q; it is last unless the next slot is ready too
          out_data_q <= '{fmab_pkg::ActDeliver, org_q, seq_q, !del};
          out_valid_q <= 1'b1;
          chain_q <= del;
          if (del) begin
            ne_q[org_q] <= seq_q + 32'd2;
            seq_q <= seq_q + 32'd1;
          end
          st_q <= StEmit;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

@@ tb/tb_fifo_majority_ack_broadcast_delivery_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_majority_ack_broadcast_delivery_top
// Drives broadcasts, message copies and acks into the delivery engine, keeps
// a shadow of its per-origin window state and compares every result beat.
// ----------------------------------------------------------------------------
module tb_fifo_majority_ack_broadcast_delivery_top;

  localparam int unsigned WdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  fmab_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fmab_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = fmab_pkg::CfgNumProc;
  logic [4:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  fifo_majority_ack_broadcast_delivery_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // shadow state
  logic [4:0] grp_size;
  logic [3:0] self_id;
  logic [31:0] next_seq [fmab_pkg::MaxProc];
  logic pend_q [fmab_pkg::Depth];
  logic [fmab_pkg::MaxProc-1:0] holders_q [fmab_pkg::Depth];
  logic [31:0] own_ctr;
  fmab_pkg::out_t beats_due [$];

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  int wdog = 0;

  function automatic int unsigned slot_idx(logic [3:0] o, logic [31:0] s);
    return o * fmab_pkg::Window + (s % fmab_pkg::Window);
  endfunction

  function automatic bit win_ok(logic [3:0] o, logic [31:0] s);
    if (s == 32'hFFFF_FFFF) return 0;
    return ({32'd0, s} - {32'd0, next_seq[o]}) < 64'(fmab_pkg::Window);
  endfunction

  function automatic bit deliverable(logic [3:0] o, logic [31:0] s);
    int unsigned k;
    k = slot_idx(o, s);
    return pend_q[k] && s == next_seq[o] && s != 32'hFFFF_FFFF &&
           $countones(holders_q[k]) > (grp_size / 2);
  endfunction

  task automatic push_beat(logic [1:0] a, logic [3:0] o, logic [31:0] s,
                           ref fmab_pkg::out_t res[$]);
    fmab_pkg::out_t b;
    b.action = a; b.out_origin = o; b.out_seq = s; b.last = 1'b0;
    res.push_back(b);
  endtask

  task automatic predict_item(fmab_pkg::in_t it);
    fmab_pkg::out_t res[$];
    int unsigned k;
    logic [31:0] ns;
    logic [3:0] o;
    if (it.req_type == fmab_pkg::ReqBcast) begin
      if (own_ctr != 32'hFFFF_FFFF) begin
        ns = own_ctr + 1;
        if (!win_ok(self_id, ns)) push_beat(fmab_pkg::ActDrop, self_id, ns, res);
        else begin
          own_ctr = ns;
          k = slot_idx(self_id, ns);
          pend_q[k] = 1'b1;
          holders_q[k][self_id] = 1'b1;
          push_beat(fmab_pkg::ActSend, self_id, ns, res);
        end
      end
    end else if (it.req_type == fmab_pkg::ReqCopy || it.req_type == fmab_pkg::ReqAck) begin
      o = it.origin_id;
      if (it.seq_num >= next_seq[o]) begin
        if (!win_ok(o, it.seq_num)) push_beat(fmab_pkg::ActDrop, o, it.seq_num, res);
        else begin
          k = slot_idx(o, it.seq_num);
          holders_q[k][it.from_id] = 1'b1;
          if (it.req_type == fmab_pkg::ReqCopy && !pend_q[k]) begin
            pend_q[k] = 1'b1;
            holders_q[k][self_id] = 1'b1;
            push_beat(fmab_pkg::ActSend, o, it.seq_num, res);
          end
          // only the item's own message can start a delivery run
          if (deliverable(o, it.seq_num)) begin
            while (deliverable(o, next_seq[o])) begin
              k = slot_idx(o, next_seq[o]);
              pend_q[k] = 1'b0;
              holders_q[k] = '0;
              push_beat(fmab_pkg::ActDeliver, o, next_seq[o], res);
              next_seq[o] = next_seq[o] + 1;
            end
          end
        end
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) beats_due.push_back(res[i]);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", out_data_o);
      end else begin
        if (out_data_o !== beats_due[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp act=%0d org=%0d seq=%h last=%0d %s%0d %s%h %s%0d",
                     beats_due[0].action, beats_due[0].out_origin,
                     beats_due[0].out_seq, beats_due[0].last,
                     "got act=", out_data_o.action, "org=", out_data_o.out_origin,
                     "seq=", out_data_o.out_seq, "last=", out_data_o.last);
        end
        void'(beats_due.pop_front());
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(fmab_pkg::in_t it);
    logic [63:0] rnd;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(it);
    if ($urandom_range(99) < send_idle) begin
      rnd = {$urandom, $urandom};
      in_valid_i <= 1'b0;
      in_data_i <= rnd[$bits(fmab_pkg::in_t)-1:0];
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (beats_due.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fmab_pkg::CfgNumProc) grp_size = val;
    else self_id = val[3:0];
    @(posedge clk_i);
  endtask

  function automatic fmab_pkg::in_t mk(logic [1:0] r, logic [3:0] o, logic [31:0] s,
                                       logic [3:0] f);
    fmab_pkg::in_t it;
    it.req_type = r; it.origin_id = o; it.seq_num = s; it.from_id = f;
    return it;
  endfunction

  // mostly well-formed traffic near each origin's window
  function automatic fmab_pkg::in_t rand_item();
    logic [3:0] o;
    logic [31:0] s;
    int unsigned p;
    o = $urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(3));
    p = $urandom_range(99);
    if (p < 80) s = next_seq[o] + $urandom_range(5);
    else if (p < 88)
      s = next_seq[o] + $urandom_range(fmab_pkg::Window - 1, fmab_pkg::Window + 3);
    else if (p < 94) s = $urandom;
    else s = next_seq[o] - $urandom_range(1, 3);
    p = $urandom_range(99);
    return mk(p < 10 ? fmab_pkg::ReqBcast : p < 45 ? fmab_pkg::ReqCopy :
              p < 97 ? fmab_pkg::ReqAck : fmab_pkg::ReqRsvd,
              o, s, 4'($urandom));
  endfunction

  typedef struct {
    fmab_pkg::in_t it;
    bit chk;
    fmab_pkg::out_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    fmab_pkg::out_t r;
    int unsigned pass_n;
    grp_size = 5'd2; self_id = '0; own_ctr = '0;
    foreach (next_seq[i]) next_seq[i] = 32'd1;
    foreach (pend_q[i]) begin pend_q[i] = 1'b0; holders_q[i] = '0; end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: typed expectations for obvious rows
    r = '{fmab_pkg::ActSend, 4'd0, 32'd1, 1'b1};
    dir_rows.push_back('{mk(fmab_pkg::ReqBcast, 4'hF, 32'hFFFF_FFFF, 4'hF), 1, r});
    r = '{fmab_pkg::ActDrop, 4'd5, 32'hFFFF_FFFF, 1'b1};
    dir_rows.push_back('{mk(fmab_pkg::ReqCopy, 4'd5, 32'hFFFF_FFFF, 4'd0), 1, r});
    r = '{fmab_pkg::ActDrop, 4'd15, 32'd33, 1'b1};
    dir_rows.push_back('{mk(fmab_pkg::ReqAck, 4'd15, 32'd33, 4'd1), 1, r});
    dir_rows.push_back('{mk(fmab_pkg::ReqCopy, 4'd3, 32'd0, 4'd1), 1, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqRsvd, 4'd3, 32'd1, 4'd1), 1, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqAck, 4'd2, 32'd1, 4'd7), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqCopy, 4'd2, 32'd2, 4'd3), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqCopy, 4'd2, 32'd1, 4'd9), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqAck, 4'd1, 32'd32, 4'd0), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqCopy, 4'd1, 32'd32, 4'd15), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqBcast, 4'd0, 32'd0, 4'd0), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqAck, 4'd0, 32'd2, 4'd1), 0, '0});
    dir_rows.push_back('{mk(fmab_pkg::ReqAck, 4'd0, 32'd2, 4'd8), 0, '0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        int unsigned before_n;
        before_n = beats_due.size();
        predict_item(dir_rows[i].it);
        // the typed row must agree with the shadow model
        if (dir_rows[i].res != '0 || beats_due.size() != before_n) begin
          if (beats_due.size() != before_n + 1 ||
              beats_due[beats_due.size()-1] != dir_rows[i].res) begin
            errors++;
            if (errors <= 10) $display("directed row %0d disagrees", i);
          end
        end
        // undo prediction, send_item predicts again
        while (beats_due.size() > before_n) void'(beats_due.pop_back());
        if (dir_rows[i].it.req_type == fmab_pkg::ReqBcast && own_ctr == 32'd1) begin
          own_ctr = '0;
          pend_q[slot_idx(self_id, 1)] = 1'b0;
          holders_q[slot_idx(self_id, 1)] = '0;
        end
      end
      send_item(dir_rows[i].it);
    end
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
      repeat (40) send_item(rand_item());
    join
    drain();

    for (pass_n = 0; pass_n < 6; pass_n++) begin
      case (pass_n)
        0: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd16); write_reg(fmab_pkg::CfgMyId, 5'd15);
        end
        1: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd0); write_reg(fmab_pkg::CfgMyId, 5'd1);
        end
        2: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd31); write_reg(fmab_pkg::CfgMyId, 5'd2);
        end
        3: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd1); write_reg(fmab_pkg::CfgMyId, 5'd0);
        end
        4: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd3); write_reg(fmab_pkg::CfgMyId, 5'd3);
        end
        default: begin
          write_reg(fmab_pkg::CfgNumProc, 5'd4); write_reg(fmab_pkg::CfgMyId, 5'd1);
        end
      endcase
      if (pass_n < 2) begin send_idle = 28; recv_idle = 45; end
      else if (pass_n < 4) begin send_idle = 45; recv_idle = 28; end
      else begin send_idle = 0; recv_idle = 0; end
      repeat (80) send_item(rand_item());
      drain();
    end

    if (errors == 0 && beats_due.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
